>>> hdl/text_terminal_writer_assert.svh
// assertion macros for the terminal writer control module (ttw_ctrl)
`ifndef TEXT_TERMINAL_WRITER_ASSERT_SVH
`define TEXT_TERMINAL_WRITER_ASSERT_SVH

// condition holds at every clock edge out of reset
`define TTW_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence holds in the same cycle as the antecedent
`define TTW_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define TTW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/ttw_pkg.sv
`timescale 1ns / 1ps
package ttw_pkg;

   // screen geometry
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = COLUMNS * ROWS;

   // field widths
   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int ADDR_W = 11;
   localparam int CELL_W = 16;
   localparam int ATTR_W = 8;
   localparam int CHAR_W = 8;
   localparam int OP_W   = 2;
   localparam int COLOR_W = 4;

   // opcodes
   localparam logic [OP_W-1:0] OP_PUT    = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
   localparam logic [OP_W-1:0] OP_SETPOS = 2'd2;
   localparam logic [OP_W-1:0] OP_READ   = 2'd3;

   // configuration register indexes
   localparam logic REG_FOREGROUND = 1'b0;
   localparam logic REG_BACKGROUND = 1'b1;

   // character codes
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
   localparam logic [CHAR_W-1:0] CH_LAST      = 8'h7F;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ_WAIT,
      ST_CLEAR,
      ST_SCROLL_COPY,
      ST_SCROLL_BLANK
   } state_type;

   // cell memory access request: one write and one read
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [CELL_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

   // one result word
   typedef struct packed {
      logic              strobe;
      logic [COL_W-1:0]  column;
      logic [ROW_W-1:0]  row;
      logic [ADDR_W-1:0] linear;
      logic              scrolled;
      logic [CELL_W-1:0] cell_value;
   } rsp_type;

   // linear cell address of a screen position
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
      logic [ADDR_W-1:0] base;
      base = ADDR_W'(row) * ADDR_W'(COLUMNS);
      return ADDR_W'(base + ADDR_W'(col));
   endfunction

endpackage

>>> hdl/ttw_cell_ram.sv
`timescale 1ns / 1ps
module ttw_cell_ram (
   input  logic                 clock,
   input  ttw_pkg::mem_req_type mem_req,
   output logic [ttw_pkg::CELL_W-1:0] rd_data
);

   logic [ttw_pkg::CELL_W-1:0] cell_mem [ttw_pkg::CELL_COUNT];
   logic [ttw_pkg::CELL_W-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         cell_mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= cell_mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/ttw_ctrl.sv
`timescale 1ns / 1ps
`include "text_terminal_writer_assert.svh"
module ttw_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [ttw_pkg::OP_W-1:0]      req_opcode,
   input  logic [ttw_pkg::CHAR_W-1:0]    req_char_code,
   input  logic [ttw_pkg::COL_W-1:0]     req_new_column,
   input  logic [5:0]                    req_new_row,
   input  logic [ttw_pkg::ADDR_W-1:0]    req_cell_index,
   input  logic [ttw_pkg::ATTR_W-1:0]    attr,
   output ttw_pkg::mem_req_type          mem_req,
   input  logic [ttw_pkg::CELL_W-1:0]    rd_data,
   output ttw_pkg::rsp_type              rsp
);

   ttw_pkg::state_type state_ff, state_in;
   logic [ttw_pkg::ADDR_W-1:0] cnt_ff, cnt_in;
   logic [ttw_pkg::COL_W-1:0]  col_ff, col_in;
   logic [ttw_pkg::ROW_W-1:0]  row_ff, row_in;
   logic                       idx_ok_ff, idx_ok_in;
   logic                       rsp_valid_ff;
   logic [ttw_pkg::COL_W-1:0]  rsp_col_ff;
   logic [ttw_pkg::ROW_W-1:0]  rsp_row_ff;
   logic [ttw_pkg::ADDR_W-1:0] rsp_linear_ff;
   logic                       rsp_scrolled_ff;
   logic [ttw_pkg::CELL_W-1:0] rsp_cell_ff;

   logic                       rsp_load;
   logic                       rsp_scrolled;
   logic [ttw_pkg::CELL_W-1:0] rsp_cell;
   logic [ttw_pkg::CELL_W-1:0] blank_cell;

   // put character decode
   logic [ttw_pkg::COL_W:0]    put_col_w;
   logic [ttw_pkg::ROW_W:0]    put_row_w;
   logic [ttw_pkg::COL_W-1:0]  put_wr_col;
   logic                       put_wr;
   logic [ttw_pkg::CELL_W-1:0] put_data;
   logic                       put_scroll;
   logic [ttw_pkg::COL_W-1:0]  put_col;
   logic [ttw_pkg::ROW_W-1:0]  put_row;

   // terms for the checks
   logic                       cursor_ok;
   logic                       same_cell_rw;
   logic                       setpos_take;
   logic                       ctrl_idle;

   assign blank_cell = {attr, ttw_pkg::CH_SPACE};

   // cursor motion and cell write for one character
   always_comb begin
      put_col_w  = {1'b0, col_ff};
      put_row_w  = {1'b0, row_ff};
      put_wr_col = col_ff;
      put_wr     = 1'b0;
      put_data   = blank_cell;
      case (req_char_code)
         ttw_pkg::CH_NEWLINE: begin
            put_col_w = '0;
            put_row_w = put_row_w + 1'b1;
         end
         ttw_pkg::CH_RETURN: begin
            put_col_w = '0;
         end
         ttw_pkg::CH_BACKSPACE: begin
            if (col_ff != '0) begin
               put_col_w  = put_col_w - 1'b1;
               put_wr_col = col_ff - 1'b1;
               put_wr     = 1'b1;
            end
         end
         default: begin
            if (req_char_code inside {[ttw_pkg::CH_SPACE:ttw_pkg::CH_LAST]}) begin
               put_wr    = 1'b1;
               put_data  = {attr, req_char_code};
               put_col_w = put_col_w + 1'b1;
            end
         end
      endcase
      // wrap past the last column
      if (put_col_w >= (ttw_pkg::COL_W+1)'(ttw_pkg::COLUMNS)) begin
         put_col_w = '0;
         put_row_w = put_row_w + 1'b1;
      end
      put_scroll = put_row_w >= (ttw_pkg::ROW_W+1)'(ttw_pkg::ROWS);
      put_col    = put_col_w[ttw_pkg::COL_W-1:0];
      put_row    = put_scroll ? ttw_pkg::ROW_W'(ttw_pkg::ROWS - 1)
                              : put_row_w[ttw_pkg::ROW_W-1:0];
   end

   // sequencer state and cursor registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ttw_pkg::ST_IDLE;
         cnt_ff       <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         idx_ok_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         idx_ok_ff    <= idx_ok_in;
         rsp_valid_ff <= rsp_load;
      end
   end

   // result word registers
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_col_ff      <= col_in;
         rsp_row_ff      <= row_in;
         rsp_linear_ff   <= ttw_pkg::cell_addr(row_in, col_in);
         rsp_scrolled_ff <= rsp_scrolled;
         rsp_cell_ff     <= rsp_cell;
      end
   end

   // next state, memory access and result load
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      idx_ok_in    = idx_ok_ff;
      rsp_load     = 1'b0;
      rsp_scrolled = 1'b0;
      rsp_cell     = '0;
      mem_req      = '0;
      busy         = (state_ff != ttw_pkg::ST_IDLE);
      case (state_ff)
         ttw_pkg::ST_IDLE: begin
            if (start) begin
               case (req_opcode)
                  ttw_pkg::OP_PUT: begin
                     mem_req.wr_en   = put_wr;
                     mem_req.wr_addr = ttw_pkg::cell_addr(row_ff, put_wr_col);
                     mem_req.wr_data = put_data;
                     col_in          = put_col;
                     row_in          = put_row;
                     if (put_scroll) begin
                        cnt_in   = '0;
                        state_in = ttw_pkg::ST_SCROLL_COPY;
                     end else begin
                        rsp_load = 1'b1;
                     end
                  end
                  ttw_pkg::OP_CLEAR: begin
                     col_in   = '0;
                     row_in   = '0;
                     cnt_in   = '0;
                     state_in = ttw_pkg::ST_CLEAR;
                  end
                  ttw_pkg::OP_SETPOS: begin
                     if ((req_new_column < ttw_pkg::COL_W'(ttw_pkg::COLUMNS)) &&
                         (req_new_row < 6'(ttw_pkg::ROWS))) begin
                        col_in = req_new_column;
                        row_in = req_new_row[ttw_pkg::ROW_W-1:0];
                     end
                     rsp_load = 1'b1;
                  end
                  ttw_pkg::OP_READ: begin
                     idx_ok_in       = req_cell_index < ttw_pkg::ADDR_W'(ttw_pkg::CELL_COUNT);
                     mem_req.rd_en   = idx_ok_in;
                     mem_req.rd_addr = req_cell_index;
                     state_in        = ttw_pkg::ST_READ_WAIT;
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         ttw_pkg::ST_READ_WAIT: begin
            rsp_load = 1'b1;
            rsp_cell = idx_ok_ff ? rd_data : '0;
            state_in = ttw_pkg::ST_IDLE;
         end
         ttw_pkg::ST_CLEAR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = cnt_ff;
            mem_req.wr_data = blank_cell;
            if (cnt_ff == ttw_pkg::ADDR_W'(ttw_pkg::CELL_COUNT - 1)) begin
               rsp_load = 1'b1;
               state_in = ttw_pkg::ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ttw_pkg::ST_SCROLL_COPY: begin
            // read one row ahead, write back what the last read returned
            if (cnt_ff < ttw_pkg::ADDR_W'(ttw_pkg::CELL_COUNT - ttw_pkg::COLUMNS)) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = cnt_ff + ttw_pkg::ADDR_W'(ttw_pkg::COLUMNS);
            end
            if (cnt_ff != '0) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = cnt_ff - 1'b1;
               mem_req.wr_data = rd_data;
            end
            if (cnt_ff == ttw_pkg::ADDR_W'(ttw_pkg::CELL_COUNT - ttw_pkg::COLUMNS)) begin
               state_in = ttw_pkg::ST_SCROLL_BLANK;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ttw_pkg::ST_SCROLL_BLANK: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = cnt_ff;
            mem_req.wr_data = blank_cell;
            if (cnt_ff == ttw_pkg::ADDR_W'(ttw_pkg::CELL_COUNT - 1)) begin
               rsp_load     = 1'b1;
               rsp_scrolled = 1'b1;
               state_in     = ttw_pkg::ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = ttw_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp.strobe     = rsp_valid_ff;
   assign rsp.column     = rsp_col_ff;
   assign rsp.row        = rsp_row_ff;
   assign rsp.linear     = rsp_linear_ff;
   assign rsp.scrolled   = rsp_scrolled_ff;
   assign rsp.cell_value = rsp_cell_ff;

   // checks
   assign cursor_ok    = (col_ff < ttw_pkg::COL_W'(ttw_pkg::COLUMNS)) &&
                         (row_ff < ttw_pkg::ROW_W'(ttw_pkg::ROWS));
   assign same_cell_rw = mem_req.wr_en && mem_req.rd_en &&
                         (mem_req.wr_addr == mem_req.rd_addr);
   assign setpos_take  = start && !busy && (req_opcode == ttw_pkg::OP_SETPOS);
   assign ctrl_idle    = (state_ff == ttw_pkg::ST_IDLE);

   `TTW_ASSERT_ALWAYS(a_cursor_on_screen, clock, reset, cursor_ok, "cursor left the screen")
   `TTW_ASSERT_ALWAYS(a_no_same_cell_rw, clock, reset, !same_cell_rw, "read and write hit one cell")
   `TTW_ASSERT_NEXT(a_setpos_answers, clock, reset, setpos_take, rsp_valid_ff, "set cursor no word")
   `TTW_ASSERT_IMPLY(a_word_when_idle, clock, reset, rsp_valid_ff, ctrl_idle, "word while walking")

endmodule

>>> hdl/text_terminal_writer.sv
`timescale 1ns / 1ps
// Character terminal over a text cell buffer (attribute byte over character byte).
// Commands: put character, clear screen, set cursor, read cell. A command word is
// taken at a rising edge with start high and busy low. Every command gives one
// result word, held on the rsp_ ports for one cycle while rsp_strobe is high; the
// receiver cannot stall it, so it must take the word in that cycle.
// Put character without scroll and set cursor load the result word at accept, so it is
// strobed in the cycle after (busy stays low, one command per cycle); read cell loads it
// after one registered memory read; clear screen writes one cell per cycle; a put that
// scrolls copies CELL_COUNT - COLUMNS cells up a row through the single read port, then
// writes a blank row of COLUMNS cells. The cell memory has one write and one registered
// read port; all buffer walks go through them one cell per cycle. Colors are set on the
// csr_ port (index 0 foreground, 1 background); the user must write them only while idle,
// as the block itself does not enforce it. Reset puts the cursor at row 0, column 0,
// foreground 15, background 0; the cell memory is not cleared, so a clear screen command
// must come before reads.
module text_terminal_writer (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_char_code,
   input  logic [6:0]  req_new_column,
   input  logic [5:0]  req_new_row,
   input  logic [10:0] req_cell_index,
   output logic        rsp_strobe,
   output logic [6:0]  rsp_cursor_column,
   output logic [4:0]  rsp_cursor_row,
   output logic [10:0] rsp_cursor_linear,
   output logic        rsp_scrolled,
   output logic [15:0] rsp_cell_value,
   input  logic        csr_write_enable,
   input  logic        csr_index,
   input  logic [3:0]  csr_write_data
);

   logic [ttw_pkg::COLOR_W-1:0] fg_ff;
   logic [ttw_pkg::COLOR_W-1:0] bg_ff;
   logic [ttw_pkg::ATTR_W-1:0]  attr;
   ttw_pkg::mem_req_type        mem_req;
   logic [ttw_pkg::CELL_W-1:0]  rd_data;
   ttw_pkg::rsp_type            rsp;

   // color registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff <= 4'd15;
         bg_ff <= 4'd0;
      end else if (csr_write_enable) begin
         case (csr_index)
            ttw_pkg::REG_FOREGROUND: fg_ff <= csr_write_data;
            ttw_pkg::REG_BACKGROUND: bg_ff <= csr_write_data;
            default: begin
               fg_ff <= fg_ff;
            end
         endcase
      end
   end

   assign attr = {bg_ff, fg_ff};

   ttw_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_opcode     (req_opcode),
      .req_char_code  (req_char_code),
      .req_new_column (req_new_column),
      .req_new_row    (req_new_row),
      .req_cell_index (req_cell_index),
      .attr           (attr),
      .mem_req        (mem_req),
      .rd_data        (rd_data),
      .rsp            (rsp)
   );

   ttw_cell_ram u_cell_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // result word out
   assign rsp_strobe        = rsp.strobe;
   assign rsp_cursor_column = rsp.column;
   assign rsp_cursor_row    = rsp.row;
   assign rsp_cursor_linear = rsp.linear;
   assign rsp_scrolled      = rsp.scrolled;
   assign rsp_cell_value    = rsp.cell_value;

endmodule

>>> tb/tb_text_terminal_writer.sv
`timescale 1ns / 1ps

// one command word as presented on the req_ ports
typedef struct packed {
   logic [1:0]  opcode;
   logic [7:0]  char_code;
   logic [6:0]  new_column;
   logic [5:0]  new_row;
   logic [10:0] cell_index;
} command_word_type;

// one result word as seen on the rsp_ ports
typedef struct packed {
   logic [6:0]  column;
   logic [4:0]  row;
   logic [10:0] linear;
   logic        scrolled;
   logic [15:0] cell_value;
} report_word_type;

// tracks screen contents and cursor, and the result words still owed
class screen_tracker;
   logic [15:0]     cells [ttw_pkg::CELL_COUNT];
   int              col;
   int              row;
   logic [3:0]      fg;
   logic [3:0]      bg;
   report_word_type awaited_reports [$];
   int              mismatch_count;

   function new();
      col = 0;
      row = 0;
      fg = 4'd15;
      bg = 4'd0;
      mismatch_count = 0;
      foreach (cells[i]) cells[i] = '0;
   endfunction

   function void set_color(logic idx, logic [3:0] value);
      if (idx == ttw_pkg::REG_FOREGROUND) fg = value;
      else bg = value;
   endfunction

   // apply one accepted command and queue the word it must produce
   function void note_command(command_word_type c);
      report_word_type r;
      logic [15:0]     blank;
      blank = {bg, fg, ttw_pkg::CH_SPACE};
      r.scrolled = 1'b0;
      r.cell_value = '0;
      case (c.opcode)
         ttw_pkg::OP_PUT: begin
            if (c.char_code == ttw_pkg::CH_NEWLINE) begin
               col = 0;
               row++;
            end else if (c.char_code == ttw_pkg::CH_RETURN) begin
               col = 0;
            end else if (c.char_code == ttw_pkg::CH_BACKSPACE) begin
               if (col > 0) begin
                  col--;
                  cells[row * ttw_pkg::COLUMNS + col] = blank;
               end
            end else if (c.char_code >= ttw_pkg::CH_SPACE &&
                         c.char_code <= ttw_pkg::CH_LAST) begin
               cells[row * ttw_pkg::COLUMNS + col] = {bg, fg, c.char_code};
               col++;
            end
            // wrap past the last column
            if (col >= ttw_pkg::COLUMNS) begin
               col = 0;
               row++;
            end
            // scroll past the last row
            if (row >= ttw_pkg::ROWS) begin
               for (int i = 0; i < ttw_pkg::CELL_COUNT - ttw_pkg::COLUMNS; i++)
                  cells[i] = cells[i + ttw_pkg::COLUMNS];
               for (int i = ttw_pkg::CELL_COUNT - ttw_pkg::COLUMNS; i < ttw_pkg::CELL_COUNT; i++)
                  cells[i] = blank;
               row = ttw_pkg::ROWS - 1;
               r.scrolled = 1'b1;
            end
         end
         ttw_pkg::OP_CLEAR: begin
            foreach (cells[i]) cells[i] = blank;
            col = 0;
            row = 0;
         end
         ttw_pkg::OP_SETPOS: begin
            if (c.new_column < ttw_pkg::COLUMNS && c.new_row < ttw_pkg::ROWS) begin
               col = c.new_column;
               row = c.new_row;
            end
         end
         default: begin
            if (c.cell_index < ttw_pkg::CELL_COUNT) r.cell_value = cells[c.cell_index];
         end
      endcase
      r.column = 7'(col);
      r.row = 5'(row);
      r.linear = 11'(row * ttw_pkg::COLUMNS + col);
      awaited_reports.push_back(r);
   endfunction

   // compare one strobed word against the oldest one owed
   function void check_report(report_word_type got);
      report_word_type want;
      if (awaited_reports.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected word: col %0d row %0d linear %0d scrolled %0d cell %h",
                     got.column, got.row, got.linear, got.scrolled, got.cell_value);
         return;
      end
      want = awaited_reports.pop_front();
      if (got.column !== want.column || got.row !== want.row || got.linear !== want.linear ||
          got.scrolled !== want.scrolled || got.cell_value !== want.cell_value) begin
         mismatch_count++;
         if (mismatch_count <= 10) begin
            $display("result mismatch at %0t", $realtime);
            $display("  expected col %0d row %0d linear %0d scrolled %0d cell %h",
                     want.column, want.row, want.linear, want.scrolled, want.cell_value);
            $display("  actual   col %0d row %0d linear %0d scrolled %0d cell %h",
                     got.column, got.row, got.linear, got.scrolled, got.cell_value);
         end
      end
   endfunction
endclass

module tb_text_terminal_writer;

   localparam int PHASE_ITEMS = 350;
   localparam int CYCLE_LIMIT = 4 * 1800 * (ttw_pkg::CELL_COUNT + 16);

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_opcode = '0;
   logic [7:0]  req_char_code = '0;
   logic [6:0]  req_new_column = '0;
   logic [5:0]  req_new_row = '0;
   logic [10:0] req_cell_index = '0;
   logic        rsp_strobe;
   logic [6:0]  rsp_cursor_column;
   logic [4:0]  rsp_cursor_row;
   logic [10:0] rsp_cursor_linear;
   logic        rsp_scrolled;
   logic [15:0] rsp_cell_value;
   logic        csr_write_enable = 1'b0;
   logic        csr_index = 1'b0;
   logic [3:0]  csr_write_data = '0;

   screen_tracker tracker = new();
   bit            idling_on = 1'b1;
   int            cycle_count = 0;

   text_terminal_writer i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_opcode        (req_opcode),
      .req_char_code     (req_char_code),
      .req_new_column    (req_new_column),
      .req_new_row       (req_new_row),
      .req_cell_index    (req_cell_index),
      .rsp_strobe        (rsp_strobe),
      .rsp_cursor_column (rsp_cursor_column),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_cursor_linear (rsp_cursor_linear),
      .rsp_scrolled      (rsp_scrolled),
      .rsp_cell_value    (rsp_cell_value),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always #2 clock = ~clock;

   // result word monitor
   always @(posedge clock) begin
      report_word_type got;
      if (!reset && rsp_strobe) begin
         got = {rsp_cursor_column, rsp_cursor_row, rsp_cursor_linear, rsp_scrolled,
                rsp_cell_value};
         tracker.check_report(got);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic command_word_type make_command(logic [1:0] op, logic [7:0] ch,
                                                     logic [6:0] col, logic [5:0] row,
                                                     logic [10:0] idx);
      command_word_type c;
      c.opcode = op;
      c.char_code = ch;
      c.new_column = col;
      c.new_row = row;
      c.cell_index = idx;
      return c;
   endfunction

   // mostly text and cursor moves, some reads, rare clears, every field randomized
   function automatic command_word_type random_command();
      command_word_type c;
      int               pick;
      c = make_command(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                       7'($urandom_range(0, 127)), 6'($urandom_range(0, 63)),
                       11'($urandom_range(0, 2047)));
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
         c.opcode = ttw_pkg::OP_CLEAR;
      end else if (pick < 58) begin
         c.opcode = ttw_pkg::OP_PUT;
         pick = $urandom_range(0, 99);
         if (pick < 68)
            c.char_code = 8'($urandom_range(ttw_pkg::CH_SPACE, ttw_pkg::CH_LAST));
         else if (pick < 76) c.char_code = ttw_pkg::CH_NEWLINE;
         else if (pick < 81) c.char_code = ttw_pkg::CH_RETURN;
         else if (pick < 89) c.char_code = ttw_pkg::CH_BACKSPACE;
      end else if (pick < 78) begin
         c.opcode = ttw_pkg::OP_SETPOS;
         if ($urandom_range(0, 99) < 75) begin
            c.new_column = 7'($urandom_range(0, ttw_pkg::COLUMNS - 1));
            c.new_row = 6'($urandom_range(0, ttw_pkg::ROWS - 1));
         end
      end else begin
         c.opcode = ttw_pkg::OP_READ;
         if ($urandom_range(0, 99) < 85)
            c.cell_index = 11'($urandom_range(0, ttw_pkg::CELL_COUNT - 1));
      end
      return c;
   endfunction

   // present one command word and hold it until taken
   task automatic send_command(input command_word_type c);
      start <= 1'b1;
      req_opcode <= c.opcode;
      req_char_code <= c.char_code;
      req_new_column <= c.new_column;
      req_new_row <= c.new_row;
      req_cell_index <= c.cell_index;
      do @(posedge clock); while (busy);
      tracker.note_command(c);
   endtask

   // random sender gap
   task automatic maybe_idle();
      if (idling_on && $urandom_range(0, 99) < 26) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
   endtask

   // stop sending until every owed word has come back
   task automatic drain();
      start <= 1'b0;
      while (tracker.awaited_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write both color registers back to back
   task automatic set_colors(input logic [3:0] fg, input logic [3:0] bg);
      csr_write_enable <= 1'b1;
      csr_index <= ttw_pkg::REG_FOREGROUND;
      csr_write_data <= fg;
      @(posedge clock);
      csr_index <= ttw_pkg::REG_BACKGROUND;
      csr_write_data <= bg;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tracker.set_color(ttw_pkg::REG_FOREGROUND, fg);
      tracker.set_color(ttw_pkg::REG_BACKGROUND, bg);
   endtask

   initial begin
      command_word_type directed [$];
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: clear first so no unwritten cell is ever read or scrolled
      directed.push_back(make_command(ttw_pkg::OP_CLEAR, 8'h00, 7'd0, 6'd0, 11'd0));
      directed.push_back(make_command(ttw_pkg::OP_PUT, 8'h41, 7'd0, 6'd0, 11'd0));
      directed.push_back(make_command(ttw_pkg::OP_PUT, ttw_pkg::CH_SPACE, 7'd0, 6'd0, 11'd0));
      directed.push_back(make_command(ttw_pkg::OP_PUT, ttw_pkg::CH_LAST, 7'd0, 6'd0, 11'd0));
      directed.push_back(make_command(ttw_pkg::OP_PUT, 8'h1F, 7'd0, 6'd0, 11'd0));
      directed.push_back(make_command(ttw_pkg::OP_PUT, 8'h80, 7'd0, 6'd0, 11'd0));
      directed.push_back(make_command(ttw_pkg::OP_PUT, 8'hFF, 7'd0, 6'd0, 11'd0));
      directed.push_back(make_command(ttw_pkg::OP_PUT, 8'h00, 7'd0, 6'd0, 11'd0));
      directed.push_back(make_command(ttw_pkg::OP_PUT, ttw_pkg::CH_BACKSPACE,
                                      7'd0, 6'd0, 11'd0));
      directed.push_back(make_command(ttw_pkg::OP_PUT, ttw_pkg::CH_RETURN, 7'd0, 6'd0, 11'd0));
      directed.push_back(make_command(ttw_pkg::OP_PUT, ttw_pkg::CH_BACKSPACE,
                                      7'd0, 6'd0, 11'd0));
      directed.push_back(make_command(ttw_pkg::OP_PUT, ttw_pkg::CH_NEWLINE, 7'd0, 6'd0, 11'd0));
      // wrap from the last column
      directed.push_back(make_command(ttw_pkg::OP_SETPOS, 8'h00, 7'(ttw_pkg::COLUMNS - 1),
                                      6'd0, 11'd0));
      directed.push_back(make_command(ttw_pkg::OP_PUT, 8'h5A, 7'd0, 6'd0, 11'd0));
      // out of range cursor requests
      directed.push_back(make_command(ttw_pkg::OP_SETPOS, 8'h00, 7'(ttw_pkg::COLUMNS),
                                      6'd0, 11'd0));
      directed.push_back(make_command(ttw_pkg::OP_SETPOS, 8'h00, 7'd0,
                                      6'(ttw_pkg::ROWS), 11'd0));
      directed.push_back(make_command(ttw_pkg::OP_SETPOS, 8'h00, 7'd127, 6'd63, 11'd0));
      // wrap into a scroll, then newline scroll on the bottom row
      directed.push_back(make_command(ttw_pkg::OP_SETPOS, 8'h00, 7'(ttw_pkg::COLUMNS - 1),
                                      6'(ttw_pkg::ROWS - 1), 11'd0));
      directed.push_back(make_command(ttw_pkg::OP_PUT, 8'h7E, 7'd0, 6'd0, 11'd0));
      directed.push_back(make_command(ttw_pkg::OP_PUT, ttw_pkg::CH_NEWLINE, 7'd0, 6'd0, 11'd0));
      // reads at both ends and past the buffer
      directed.push_back(make_command(ttw_pkg::OP_READ, 8'h00, 7'd0, 6'd0, 11'd0));
      directed.push_back(make_command(ttw_pkg::OP_READ, 8'h00, 7'd0, 6'd0,
                                      11'(ttw_pkg::CELL_COUNT - 1)));
      directed.push_back(make_command(ttw_pkg::OP_READ, 8'h00, 7'd0, 6'd0,
                                      11'(ttw_pkg::CELL_COUNT)));
      directed.push_back(make_command(ttw_pkg::OP_READ, 8'h00, 7'd0, 6'd0, 11'd2047));
      directed.push_back(make_command(ttw_pkg::OP_SETPOS, 8'h00, 7'd0, 6'd0, 11'd0));
      foreach (directed[i]) begin
         maybe_idle();
         send_command(directed[i]);
      end

      // random phases under different colors, the first one without gaps
      for (int phase = 1; phase <= 5; phase++) begin
         drain();
         case (phase)
            1: set_colors(4'd0, 4'd0);
            2: set_colors(4'd15, 4'd15);
            3: set_colors(4'd0, 4'd15);
            default: set_colors(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
         endcase
         idling_on = (phase != 1);
         repeat (PHASE_ITEMS) begin
            maybe_idle();
            send_command(random_command());
            if ($urandom_range(0, 199) == 0) drain();
         end
      end

      drain();
      repeat (ttw_pkg::CELL_COUNT + 8) @(posedge clock);
      if (tracker.mismatch_count == 0 && tracker.awaited_reports.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
